>>> rtl/sss_pkg.sv
// Shared constants, types and a helper function of the servo slew sequencer.
package sss_pkg;

  localparam int STEP_DEPTH = 8;
  localparam int STEP_IDX_W = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;
  localparam int STEP_CNT_W = $clog2(STEP_DEPTH + 1);

  localparam logic [15:0] ANGLE_MAX      = 16'd46080;
  localparam logic [15:0] FLOOR_RST      = 16'd7680;
  localparam logic [15:0] CEILING_RST    = 16'd38400;
  localparam logic [11:0] DEADBAND_RST   = 12'd128;
  localparam logic [11:0] SEQ_SPEED_RST  = 12'd896;
  localparam logic [15:0] POSITION_RST   = 16'd23040;
  localparam logic [11:0] SLEW_SPEED_RST = 12'd512;
  localparam logic [31:0] NO_TICK_DT     = 32'd20;
  localparam logic [16:0] ROUND_HALF     = 17'd128;

  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_AIM  = 2'd1,
    FUNC_LOAD = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    REG_ANGLE_FLOOR    = 2'd0,
    REG_ANGLE_CEILING  = 2'd1,
    REG_DEADBAND       = 2'd2,
    REG_SEQUENCE_SPEED = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] hold;
    logic [15:0] angle;
  } step_t;

  typedef struct packed {
    logic                  we;
    logic [STEP_IDX_W-1:0] addr;
    step_t                 data;
  } store_wr_t;

  // Crossed limits give the floor under it, else the ceiling; max 180 degrees.
  function automatic logic [15:0] clamp_angle(input logic [15:0] a,
                                              input logic [15:0] floor_v,
                                              input logic [15:0] ceil_v);
    logic [15:0] v;
    v = a;
    if (v < floor_v) begin
      v = floor_v;
    end else if (v > ceil_v) begin
      v = ceil_v;
    end
    if (v > ANGLE_MAX) begin
      v = ANGLE_MAX;
    end
    return v;
  endfunction

endpackage

>>> rtl/servo_slew_sequencer.sv
// Top level of the servo slew sequencer: stream ports, state and item control.
//
// Accepts one item per clock and returns one result per item: the item is
// captured in an input register, then a single pass of
// clamp, step-advance, multiply and compare logic updates the state and loads the
// result register. A result waiting on m_axis_tready holds the input register, so
// s_axis_tready follows m_axis_tready combinationally while both stages are full.
// One item per cycle is sustained while the result side keeps up; the 12 x 32 bit
// multiply in the slew path is the longest logic path and sets the clock rate.
module servo_slew_sequencer
  import sss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,   // time_ms, angle_q, speed_q, hold_ms, zero fill
  input  logic [1:0]  s_axis_tuser,   // func
  input  logic        s_axis_tlast,   // last_step
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // servo_angle, position_q, playing, zero fill
  output logic        m_axis_tuser    // write_strobe
);

  // Configuration registers.
  logic [15:0] floor_q, ceiling_q;
  logic [11:0] deadband_q, seq_speed_q;

  // Input stage.
  logic        in_valid_q;
  logic [1:0]  in_func_q;
  logic [31:0] in_time_q;
  logic [15:0] in_angle_q;
  logic [11:0] in_speed_q;
  logic [15:0] in_hold_q;
  logic        in_last_q;

  // Result stage.
  logic        out_valid_q;
  logic        out_strobe_q;
  logic [7:0]  out_angle_q;
  logic [15:0] out_pos_q;
  logic        out_playing_q;

  // Block state.
  logic [15:0]           position_q, position_d;
  logic [15:0]           target_q, target_d;
  logic [11:0]           speed_q, speed_d;
  logic [31:0]           last_tick_q, last_tick_d;
  logic [31:0]           deadline_q, deadline_d;
  logic [STEP_CNT_W-1:0] load_ptr_q, load_ptr_d;
  logic [STEP_CNT_W-1:0] total_q, total_d;
  logic [STEP_CNT_W-1:0] step_pos_q, step_pos_d;
  logic                  active_q, active_d;

  logic                  advance;
  logic                  is_tick;
  logic [31:0]           dt;
  logic [STEP_CNT_W-1:0] next_pos;
  logic [STEP_CNT_W-1:0] ptr_inc;
  logic                  move;
  logic [15:0]           slew_pos;
  logic [16:0]           rounded;
  store_wr_t             store_wr;
  step_t                 rd_step, head_step;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_strobe_q;
  assign m_axis_tdata  = {7'b0, out_playing_q, out_pos_q, out_angle_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q     <= FLOOR_RST;
      ceiling_q   <= CEILING_RST;
      deadband_q  <= DEADBAND_RST;
      seq_speed_q <= SEQ_SPEED_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_ANGLE_FLOOR:    floor_q     <= cfg_wdata_i;
        REG_ANGLE_CEILING:  ceiling_q   <= cfg_wdata_i;
        REG_DEADBAND:       deadband_q  <= cfg_wdata_i[11:0];
        REG_SEQUENCE_SPEED: seq_speed_q <= cfg_wdata_i[11:0];
        default: ;
      endcase
    end
  end

  sss_step_store u_store (
    .clk_i     (clk_i),
    .wr_i      (store_wr),
    .rd_idx_i  (next_pos[STEP_IDX_W-1:0]),
    .rd_data_o (rd_step),
    .head_o    (head_step)
  );

  sss_slew u_slew (
    .position_i (position_q),
    .target_i   (target_d),
    .speed_i    (speed_d),
    .dt_i       (dt),
    .deadband_i (deadband_q),
    .move_o     (move),
    .position_o (slew_pos)
  );

  always_comb begin
    target_d      = target_q;
    speed_d       = speed_q;
    last_tick_d   = last_tick_q;
    deadline_d    = deadline_q;
    load_ptr_d    = load_ptr_q;
    total_d       = total_q;
    step_pos_d    = step_pos_q;
    active_d      = active_q;
    position_d    = position_q;
    store_wr.we   = 1'b0;
    store_wr.addr = load_ptr_q[STEP_IDX_W-1:0];
    store_wr.data = '{hold: in_hold_q, angle: in_angle_q};
    is_tick       = 1'b0;
    dt            = (last_tick_q == '0) ? NO_TICK_DT : (in_time_q - last_tick_q);
    next_pos      = step_pos_q + 1'b1;
    ptr_inc       = load_ptr_q;

    case (in_func_q)
      FUNC_TICK: begin
        is_tick     = 1'b1;
        last_tick_d = in_time_q;
        if (active_q && (total_q != '0) && (in_time_q >= deadline_q)) begin
          step_pos_d = next_pos;
          if (next_pos < total_q) begin
            deadline_d = in_time_q + {16'b0, rd_step.hold};
            target_d   = clamp_angle(rd_step.angle, floor_q, ceiling_q);
            speed_d    = seq_speed_q;
          end else begin
            active_d = 1'b0;
            total_d  = '0;
          end
        end
        position_d = slew_pos;
      end
      FUNC_AIM: begin
        target_d = clamp_angle(in_angle_q, floor_q, ceiling_q);
        speed_d  = in_speed_q;
        active_d = 1'b0;
      end
      FUNC_LOAD: begin
        // Loads past the end of the store are dropped.
        if (load_ptr_q < STEP_CNT_W'(STEP_DEPTH)) begin
          store_wr.we = advance;
          ptr_inc     = load_ptr_q + 1'b1;
        end
        load_ptr_d = ptr_inc;
        if (in_last_q) begin
          total_d    = ptr_inc;
          load_ptr_d = '0;
          step_pos_d = '0;
          active_d   = 1'b1;
          deadline_d = in_time_q + {16'b0, head_step.hold};
          target_d   = clamp_angle(head_step.angle, floor_q, ceiling_q);
          speed_d    = seq_speed_q;
        end
      end
      default: ;
    endcase

    rounded = {1'b0, position_d} + ROUND_HALF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      position_q  <= POSITION_RST;
      target_q    <= POSITION_RST;
      speed_q     <= SLEW_SPEED_RST;
      last_tick_q <= '0;
      deadline_q  <= '0;
      load_ptr_q  <= '0;
      total_q     <= '0;
      step_pos_q  <= '0;
      active_q    <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        position_q  <= position_d;
        target_q    <= target_d;
        speed_q     <= speed_d;
        last_tick_q <= last_tick_d;
        deadline_q  <= deadline_d;
        load_ptr_q  <= load_ptr_d;
        total_q     <= total_d;
        step_pos_q  <= step_pos_d;
        active_q    <= active_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q  <= s_axis_tuser;
      in_time_q  <= s_axis_tdata[31:0];
      in_angle_q <= s_axis_tdata[47:32];
      in_speed_q <= s_axis_tdata[59:48];
      in_hold_q  <= s_axis_tdata[75:60];
      in_last_q  <= s_axis_tlast;
    end
    if (advance) begin
      out_strobe_q  <= is_tick && move;
      out_angle_q   <= rounded[15:8];
      out_pos_q     <= position_d;
      out_playing_q <= active_d;
    end
  end

endmodule

>>> rtl/sss_step_store.sv
// Keyframe store: one write port, one indexed read port and a bypassed head entry.
module sss_step_store
  import sss_pkg::*;
(
  input  logic                  clk_i,
  input  store_wr_t             wr_i,
  input  logic [STEP_IDX_W-1:0] rd_idx_i,
  output step_t                 rd_data_o,
  output step_t                 head_o
);

  step_t store_q [STEP_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      store_q[wr_i.addr] <= wr_i.data;
    end
  end

  assign rd_data_o = store_q[rd_idx_i];

  // A one-step load starts playback from the entry it is writing right now.
  assign head_o = (wr_i.we && (wr_i.addr == '0)) ? wr_i.data : store_q[0];

endmodule

>>> rtl/sss_slew.sv
// Slew step: moves the position toward the target by at most speed times elapsed time.
module sss_slew
  import sss_pkg::*;
(
  input  logic [15:0] position_i,
  input  logic [15:0] target_i,
  input  logic [11:0] speed_i,
  input  logic [31:0] dt_i,
  input  logic [11:0] deadband_i,
  output logic        move_o,
  output logic [15:0] position_o
);

  logic [15:0] err;
  logic [43:0] product;
  logic [15:0] step;
  logic [16:0] sum;
  logic [15:0] moved;

  always_comb begin
    err     = (position_i > target_i) ? (position_i - target_i) : (target_i - position_i);
    move_o  = err > {4'b0, deadband_i};
    product = 44'(speed_i) * 44'(dt_i);
    step    = (product > 44'(ANGLE_MAX)) ? ANGLE_MAX : product[15:0];
    sum     = {1'b0, position_i} + {1'b0, step};
    if (target_i > position_i) begin
      moved = (sum > {1'b0, target_i}) ? target_i : sum[15:0];
    end else begin
      moved = (step >= err) ? target_i : (position_i - step);
    end
    position_o = move_o ? moved : position_i;
  end

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the servo slew sequencer: stream stimulus and a position predictor.
`timescale 1ns / 100ps

module tb_top;
  import sss_pkg::*;

  typedef struct packed {
    func_e       func;
    logic [31:0] time_ms;
    logic [15:0] angle;
    logic [11:0] speed;
    logic [15:0] hold;
    logic        last;
  } servo_cmd_t;

  typedef struct packed {
    logic        strobe;
    logic [7:0]  degrees;
    logic [15:0] position;
    logic        playing;
  } servo_report_t;

  class slew_scoreboard;
    logic [15:0] floor_q, ceil_q;
    logic [11:0] band_q, seq_speed_q;
    logic [15:0] pos, tgt;
    logic [11:0] rate;
    logic [31:0] last_tick, deadline;
    step_t keyframes[STEP_DEPTH];
    int unsigned load_ptr, frame_total, frame_idx;
    bit active;
    servo_report_t expected_reports[$];
    int errors;

    function new();
      floor_q = FLOOR_RST;
      ceil_q = CEILING_RST;
      band_q = DEADBAND_RST;
      seq_speed_q = SEQ_SPEED_RST;
      pos = POSITION_RST;
      tgt = POSITION_RST;
      rate = SLEW_SPEED_RST;
      last_tick = '0;
      deadline = '0;
      foreach (keyframes[i]) keyframes[i] = '0;
      load_ptr = 0;
      frame_total = 0;
      frame_idx = 0;
      active = 1'b0;
      errors = 0;
    endfunction

    function void set_register(cfg_reg_e idx, logic [15:0] v);
      case (idx)
        REG_ANGLE_FLOOR:    floor_q = v;
        REG_ANGLE_CEILING:  ceil_q = v;
        REG_DEADBAND:       band_q = v[11:0];
        REG_SEQUENCE_SPEED: seq_speed_q = v[11:0];
        default: ;
      endcase
    endfunction

    // When the limits cross, inputs below the floor get the floor and all others the ceiling.
    function logic [15:0] limit_angle(logic [15:0] a);
      logic [15:0] v;
      v = a;
      if (v < floor_q) begin
        v = floor_q;
      end else if (v > ceil_q) begin
        v = ceil_q;
      end
      if (v > ANGLE_MAX) begin
        v = ANGLE_MAX;
      end
      return v;
    endfunction

    function void start_keyframe(logic [31:0] now, int unsigned idx);
      step_t k;
      k = keyframes[idx % STEP_DEPTH];
      deadline = now + 32'(k.hold);
      tgt = limit_angle(k.angle);
      rate = seq_speed_q;
    endfunction

    function bit advance_tick(logic [31:0] now);
      logic [31:0] dt;
      logic [15:0] err;
      logic [63:0] stride;
      logic [16:0] sum;
      dt = (last_tick == 32'd0) ? NO_TICK_DT : now - last_tick;
      last_tick = now;
      if (active && frame_total != 0 && now >= deadline) begin
        frame_idx++;
        if (frame_idx < frame_total) begin
          start_keyframe(now, frame_idx);
        end else begin
          active = 1'b0;
          frame_total = 0;
        end
      end
      err = (pos > tgt) ? pos - tgt : tgt - pos;
      if (err <= band_q) return 1'b0;
      stride = 64'(rate) * 64'(dt);
      if (stride > 64'(ANGLE_MAX)) stride = 64'(ANGLE_MAX);
      if (tgt > pos) begin
        sum = {1'b0, pos} + stride[16:0];
        pos = (sum > {1'b0, tgt}) ? tgt : sum[15:0];
      end else if (stride[15:0] >= pos - tgt) begin
        pos = tgt;
      end else begin
        pos = pos - stride[15:0];
      end
      return 1'b1;
    endfunction

    function void note_command(servo_cmd_t c);
      servo_report_t r;
      logic [16:0] rounded;
      r.strobe = 1'b0;
      case (c.func)
        FUNC_TICK: r.strobe = advance_tick(c.time_ms);
        FUNC_AIM: begin
          tgt = limit_angle(c.angle);
          rate = c.speed;
          active = 1'b0;
        end
        FUNC_LOAD: begin
          // Loads past the end of the store are dropped; the last mark still starts playback.
          if (load_ptr < STEP_DEPTH) begin
            keyframes[load_ptr] = {c.hold, c.angle};
            load_ptr++;
          end
          if (c.last) begin
            frame_total = load_ptr;
            load_ptr = 0;
            frame_idx = 0;
            active = 1'b1;
            start_keyframe(c.time_ms, 0);
          end
        end
        default: ;
      endcase
      rounded = {1'b0, pos} + 17'd128;
      r.degrees = rounded[15:8];
      r.position = pos;
      r.playing = active;
      expected_reports.push_back(r);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(servo_report_t got);
      servo_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: result with none expected, position %0d", $time, got.position);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      check_field("write_strobe", want.strobe, got.strobe);
      check_field("servo_angle", want.degrees, got.degrees);
      check_field("position_q", want.position, got.position);
      check_field("playing", want.playing, got.playing);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  slew_scoreboard sb;
  logic [31:0]    clock_ms;
  int             items_sent;
  bit             quiet = 1'b0;

  servo_slew_sequencer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic servo_cmd_t tick_cmd(logic [31:0] t);
    servo_cmd_t c;
    c.func = FUNC_TICK;
    c.time_ms = t;
    c.angle = 16'($urandom_range(0, ANGLE_MAX));
    c.speed = 12'($urandom);
    c.hold = 16'($urandom);
    c.last = 1'($urandom);
    return c;
  endfunction

  function automatic servo_cmd_t aim_cmd(logic [15:0] a, logic [11:0] s);
    servo_cmd_t c;
    c.func = FUNC_AIM;
    c.time_ms = $urandom;
    c.angle = a;
    c.speed = s;
    c.hold = 16'($urandom);
    c.last = 1'($urandom);
    return c;
  endfunction

  function automatic servo_cmd_t load_cmd(logic [15:0] a, logic [15:0] h, logic l,
                                          logic [31:0] t);
    servo_cmd_t c;
    c.func = FUNC_LOAD;
    c.time_ms = t;
    c.angle = a;
    c.speed = 12'($urandom);
    c.hold = h;
    c.last = l;
    return c;
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return ANGLE_MAX;
      default: return 16'($urandom_range(0, ANGLE_MAX));
    endcase
  endfunction

  function automatic logic [11:0] pick_speed();
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd4095;
      2: return 12'($urandom);
      default: return 12'($urandom_range(0, 800));
    endcase
  endfunction

  function automatic logic [15:0] pick_hold();
    case ($urandom_range(0, 19))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 30));
    endcase
  endfunction

  // Mostly a steady millisecond clock, with jumps, restarts at zero and wraparound.
  function automatic logic [31:0] next_time();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      clock_ms = clock_ms + $urandom_range(0, 40);
    end else if (pick < 93) begin
      clock_ms = clock_ms + $urandom_range(41, 100000);
    end else if (pick < 96) begin
      clock_ms = 32'd0;
    end else if (pick < 98) begin
      clock_ms = $urandom;
    end else begin
      clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 30);
    end
    return clock_ms;
  endfunction

  // Valid stays high from one item to the next unless an idle burst is inserted.
  task automatic send_cmd(servo_cmd_t c);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_axis_tdata <= {4'b0, c.hold, c.speed, c.angle, c.time_ms};
    s_axis_tuser <= c.func;
    s_axis_tlast <= c.last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(c);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    sb.set_register(idx, v);
  endtask

  task automatic configure(logic [15:0] lo, logic [15:0] hi, logic [11:0] band,
                           logic [11:0] spd);
    drain();
    write_reg(REG_ANGLE_FLOOR, lo);
    write_reg(REG_ANGLE_CEILING, hi);
    write_reg(REG_DEADBAND, {4'b0, band});
    write_reg(REG_SEQUENCE_SPEED, {4'b0, spd});
    cfg_we_i <= 1'b0;
  endtask

  // A load run ending in the last mark, then ticks to play it; unfinished runs are left hanging.
  task automatic play_sequence(bit finish);
    int steps;
    bit mark;
    if (!finish) begin
      steps = $urandom_range(1, 4);
    end else if ($urandom_range(0, 9) == 0) begin
      steps = $urandom_range(STEP_DEPTH + 1, STEP_DEPTH + 3);
    end else begin
      steps = $urandom_range(1, STEP_DEPTH);
    end
    for (int i = 0; i < steps; i++) begin
      mark = finish && (i == steps - 1);
      send_cmd(load_cmd(pick_angle(), pick_hold(), mark, mark ? clock_ms : $urandom));
    end
    if (finish) begin
      repeat ($urandom_range(4, 24)) begin
        clock_ms = clock_ms + $urandom_range(0, 12);
        send_cmd(tick_cmd(clock_ms));
      end
    end else if ($urandom_range(0, 1) == 1) begin
      send_cmd(aim_cmd(pick_angle(), pick_speed()));
    end
  endtask

  task automatic run_phase(int count);
    int stop;
    int unsigned pick;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_cmd(tick_cmd(next_time()));
      end else if (pick < 70) begin
        send_cmd(aim_cmd(pick_angle(), pick_speed()));
      end else if (pick < 92) begin
        play_sequence(1'b1);
      end else begin
        play_sequence(1'b0);
      end
    end
  endtask

  always @(posedge clk_i) begin
    servo_report_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.strobe = m_axis_tuser;
      got.degrees = m_axis_tdata[7:0];
      got.position = m_axis_tdata[23:8];
      got.playing = m_axis_tdata[24];
      sb.check_report(got);
    end
  end

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #1000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    sb = new();
    clock_ms = 32'd0;
    items_sent = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_addr_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    s_axis_tlast = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // A zero stamp on the previous tick means a default elapsed time of 20 ms.
    send_cmd(tick_cmd(32'd0));
    send_cmd(aim_cmd(16'd0, 12'd4095));
    send_cmd(tick_cmd(32'd0));
    send_cmd(aim_cmd(ANGLE_MAX, 12'd0));
    send_cmd(tick_cmd(32'd100));
    send_cmd(aim_cmd(ANGLE_MAX, 12'd1));
    send_cmd(tick_cmd(32'hFFFF_FFFF));
    send_cmd(tick_cmd(32'd5));
    // Error exactly at the deadband, then one above it.
    send_cmd(aim_cmd(CEILING_RST - 16'd128, 12'd4095));
    send_cmd(tick_cmd(32'd10));
    send_cmd(aim_cmd(CEILING_RST - 16'd129, 12'd4095));
    send_cmd(tick_cmd(32'd15));
    send_cmd(load_cmd(16'd10000, 16'd5, 1'b0, $urandom));
    send_cmd(load_cmd(ANGLE_MAX, 16'd0, 1'b0, $urandom));
    send_cmd(load_cmd(16'd0, 16'hFFFF, 1'b1, 32'd20));
    send_cmd(tick_cmd(32'd22));
    send_cmd(tick_cmd(32'd25));
    send_cmd(tick_cmd(32'd26));
    send_cmd(tick_cmd(32'd30));
    send_cmd(aim_cmd(POSITION_RST, SLEW_SPEED_RST));
    send_cmd(load_cmd(ANGLE_MAX, 16'd0, 1'b1, 32'd40));
    send_cmd(tick_cmd(32'd40));
    send_cmd(tick_cmd(32'd41));
    clock_ms = 32'd41;

    run_phase(200);
    configure(16'd0, ANGLE_MAX, 12'd0, 12'd4095);
    run_phase(200);
    configure(ANGLE_MAX, 16'd0, 12'd2560, 12'd0);
    run_phase(150);
    configure(16'($urandom_range(0, 23040)), 16'($urandom_range(23040, ANGLE_MAX)),
              12'($urandom_range(0, 2560)), 12'($urandom));
    run_phase(200);
    begin
      logic [15:0] pin;
      pin = 16'($urandom_range(0, ANGLE_MAX));
      configure(pin, pin, 12'($urandom_range(0, 2560)), 12'($urandom));
    end
    run_phase(150);
    configure(FLOOR_RST, CEILING_RST, DEADBAND_RST, SEQ_SPEED_RST);
    quiet = 1'b1;
    run_phase(250);

    s_axis_tvalid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> servo_slew_sequencer.f
rtl/sss_pkg.sv
rtl/sss_step_store.sv
rtl/sss_slew.sv
rtl/servo_slew_sequencer.sv
sim/tb_top.sv
